FILE: sv/tbmp_pkg.sv
// ----------------------------------------------------------------------------
// tbmp_pkg
// Shared types, widths, register indexes and helpers of the dual trackball
// motion processor.
// ----------------------------------------------------------------------------
package tbmp_pkg;

  // channel widths
  localparam int SAMPLE_W   = 8;
  localparam int ELAPSED_W  = 16;
  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // arithmetic widths
  localparam int MUL_A_W    = 17;
  localparam int MUL_B_W    = 16;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int SQRT_IN_W  = 32;
  localparam int SQRT_OUT_W = SQRT_IN_W / 2;
  localparam int DIV_N_W    = 9;
  localparam int DIV_D_W    = 8;
  localparam int FACTOR_W   = 16;
  localparam int AVG_W      = 24;
  localparam int ACC_W      = 12;
  localparam int REM_W      = 9;
  localparam int STEP_W     = 10;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_IDLE_TIME  = 3'd0,
    REG_SCROLL_DIV_H = 3'd1,
    REG_SCROLL_DIV_V = 3'd2,
    REG_ARROW_STEP = 3'd3,
    REG_MAX_SCALE  = 3'd4,
    REG_MIN_SCALE  = 3'd5,
    REG_SPEED_MOM  = 3'd6,
    REG_ARROW_MOM  = 3'd7
  } cfg_reg_t;

  // register reset values
  localparam logic [15:0] RST_IDLE_TIME  = 16'd1;
  localparam logic [7:0]  RST_SCROLL_DIV = 8'd10;
  localparam logic [9:0]  RST_ARROW_STEP = 10'd50;
  localparam logic [15:0] RST_MAX_SCALE  = 16'd8192;
  localparam logic [15:0] RST_MIN_SCALE  = 16'd128;
  localparam logic [15:0] RST_SPEED_MOM  = 16'd6554;
  localparam logic [15:0] RST_ARROW_MOM  = 16'd328;

  // arrow tap codes
  typedef enum logic [1:0] {
    ARROW_NONE = 2'd0,
    ARROW_NEG  = 2'd1,
    ARROW_POS  = 2'd2
  } arrow_code_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SQRT, S_SPD, S_PX, S_PY,
    S_DIVH, S_DIVV, S_AVX, S_AVY, S_ACC, S_OUT
  } state_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    arrow_code_t             code;
  } tap_t;

  // one tap decision on an accumulator
  function automatic tap_t arrow_tap(input logic signed [ACC_W-1:0] acc,
                                     input logic [STEP_W-1:0] step);
    logic signed [ACC_W:0] a;
    logic signed [ACC_W:0] s;
    tap_t r;
    a = {acc[ACC_W-1], acc};
    s = $signed({{(ACC_W+1-STEP_W){1'b0}}, step});
    r.code = ARROW_NONE;
    if (a <= -s) begin
      r.code = ARROW_NEG;
      a = a + s;
    end
    if (a >= s) begin
      r.code = ARROW_POS;
      a = a - s;
    end
    r.acc = a[ACC_W-1:0];
    return r;
  endfunction

endpackage

FILE: sv/tbmp_mul.sv
// ----------------------------------------------------------------------------
// tbmp_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module tbmp_mul import tbmp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic               done,
  output logic [MUL_P_W-1:0] prod
);

  localparam int CNT_W = $clog2(MUL_B_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(MUL_B_W - 1);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [MUL_A_W-1:0] a_r;
  logic [MUL_P_W-1:0] prod_r;
  logic [MUL_A_W:0]   sum;

  // add the multiplicand into the upper half when the low bit is set
  assign sum = {1'b0, prod_r[MUL_P_W-1:MUL_B_W]} +
               (prod_r[0] ? {1'b0, a_r} : {(MUL_A_W+1){1'b0}});

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // product shift register
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      a_r    <= a;
      prod_r <= {{MUL_A_W{1'b0}}, b};
    end else if (busy_r) begin
      prod_r <= {sum, prod_r[MUL_B_W-1:1]};
    end
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule

FILE: sv/tbmp_sqrt.sv
// ----------------------------------------------------------------------------
// tbmp_sqrt
// Digit-serial integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module tbmp_sqrt import tbmp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [SQRT_IN_W-1:0]  radicand,
  output logic                  done,
  output logic [SQRT_OUT_W-1:0] root
);

  localparam int CNT_W = $clog2(SQRT_OUT_W);
  localparam int REM_W_L = SQRT_OUT_W + 3;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(SQRT_OUT_W - 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [SQRT_IN_W-1:0]  rad_r;
  logic [REM_W_L-1:0]    rem_r;
  logic [SQRT_OUT_W-1:0] root_r;
  logic [REM_W_L-1:0]    r2;
  logic [REM_W_L-1:0]    trial;

  // bring down two radicand bits and try a one in the next root place
  assign r2    = {rem_r[REM_W_L-3:0], rad_r[SQRT_IN_W-1:SQRT_IN_W-2]};
  assign trial = {1'b0, root_r, 2'b01};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // root and remainder
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[SQRT_IN_W-3:0], 2'b00};
      if (r2 >= trial) begin
        rem_r  <= r2 - trial;
        root_r <= {root_r[SQRT_OUT_W-2:0], 1'b1};
      end else begin
        rem_r  <= r2;
        root_r <= {root_r[SQRT_OUT_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

FILE: sv/tbmp_div.sv
// ----------------------------------------------------------------------------
// tbmp_div
// Restoring serial divider for scroll steps, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tbmp_div import tbmp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  output logic               done,
  output logic [DIV_N_W-1:0] quo,
  output logic [DIV_D_W-1:0] rem
);

  localparam int CNT_W = $clog2(DIV_N_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_N_W - 1);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DIV_N_W-1:0] quo_r;
  logic [DIV_D_W-1:0] rem_r;
  logic [DIV_D_W-1:0] d_r;
  logic [DIV_D_W:0]   r;

  // partial remainder with the next dividend bit
  assign r = {rem_r, quo_r[DIV_N_W-1]};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient and remainder shift
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      quo_r <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      if (r >= {1'b0, d_r}) begin
        rem_r <= DIV_D_W'(r - {1'b0, d_r});
        quo_r <= {quo_r[DIV_N_W-2:0], 1'b1};
      end else begin
        rem_r <= r[DIV_D_W-1:0];
        quo_r <= {quo_r[DIV_N_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

FILE: sv/dual_trackball_motion_processor.sv
// ----------------------------------------------------------------------------
// dual_trackball_motion_processor
// Pointer scaling by a smoothed speed factor, scroll steps or arrow taps.
// ----------------------------------------------------------------------------
// One sample is in work at a time; the next sample is accepted the cycle after
// the result register loads, and that register loads only when the output is free.
// Each sample runs through the shared bit-serial multiplier (three multiplies in
// scroll mode, five in arrow mode), the square root, and in scroll mode two
// divisions.
// Reset (rst_n low, synchronous) loads register defaults and clears the sequencer,
// the output valid flag and the persistent history; the speed factor restarts at 128.
module dual_trackball_motion_processor import tbmp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // left_dx, left_dy, right_dx, right_dy, elapsed_seconds
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // base_layer, swap_sides
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pointer_x, pointer_y, scroll_horizontal, scroll_vertical,
  // arrow_horizontal, arrow_vertical, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  state_t state_r, state_nxt;

  // configuration
  logic [15:0] idle_time_r, max_r, min_r, spd_m_r, arw_m_r;
  logic [7:0]  div_h_r, div_v_r;
  logic [STEP_W-1:0] step_r;

  // persistent state
  logic signed [SAMPLE_W-1:0] prev_r [4];
  logic [FACTOR_W-1:0]        f_r;
  logic signed [REM_W-1:0]    rem_h_r, rem_v_r;
  logic signed [AVG_W-1:0]    avg_x_r, avg_y_r;
  logic signed [ACC_W-1:0]    acc_x_r, acc_y_r;

  // per-sample work registers
  logic signed [SAMPLE_W-1:0] px_r, py_r, sx_r, sy_r;
  logic                       base_r;
  logic [15:0]                sumsq_r;
  logic [SQRT_OUT_W-1:0]      len_r;
  logic signed [15:0]         ptr_x_r, ptr_y_r;
  logic signed [7:0]          scr_h_r, scr_v_r;
  arrow_code_t                arw_h_r, arw_v_r;
  logic                       launched_r;
  logic                       out_valid_r;
  logic [OUT_DATA_W-1:0]      out_data_r;

  // unit handshakes
  logic mul_start, mul_done, sqrt_start, sqrt_done, div_start, div_done;
  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic [MUL_P_W-1:0]    mul_prod;
  logic [SQRT_OUT_W-1:0] sqrt_root;
  logic [DIV_N_W-1:0]    div_n, div_quo;
  logic [DIV_D_W-1:0]    div_d, div_rem;

  logic in_fire, out_free;

  // input fields
  logic signed [SAMPLE_W-1:0] raw [4];
  logic [ELAPSED_W-1:0]       elapsed;
  logic                       same;

  assign raw[0]  = in_tdata[7:0];
  assign raw[1]  = in_tdata[15:8];
  assign raw[2]  = in_tdata[23:16];
  assign raw[3]  = in_tdata[31:24];
  assign elapsed = in_tdata[47:32];
  assign same    = (raw[0] == prev_r[0]) && (raw[1] == prev_r[1]) &&
                   (raw[2] == prev_r[2]) && (raw[3] == prev_r[3]) &&
                   (elapsed > idle_time_r);

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // speed and multiplier operands
  logic [16:0]             inst;
  logic signed [17:0]      spd_diff;
  logic [FACTOR_W-1:0]     mult;
  logic signed [AVG_W-1:0] s256_x, s256_y, s256_sel, mul_val, mul_mag;
  logic                    mul_neg;

  assign inst     = {1'b0, len_r} + {1'b0, min_r};
  assign spd_diff = $signed({1'b0, inst}) - $signed({2'b00, f_r});
  assign mult     = (f_r > max_r) ? max_r : f_r;
  assign s256_x   = {{8{sx_r[7]}}, sx_r, 8'h00};
  assign s256_y   = {{8{sy_r[7]}}, sy_r, 8'h00};

  always_comb begin
    mul_val  = '0;
    mul_b    = '0;
    s256_sel = s256_x;
    case (state_r)
      S_SPD: begin
        mul_val = {{(AVG_W-18){spd_diff[17]}}, spd_diff};
        mul_b   = spd_m_r;
      end
      S_PX: begin
        mul_val = {{(AVG_W-SAMPLE_W){px_r[7]}}, px_r};
        mul_b   = mult;
      end
      S_PY: begin
        mul_val = {{(AVG_W-SAMPLE_W){py_r[7]}}, py_r};
        mul_b   = mult;
      end
      S_AVX: begin
        mul_val = avg_x_r - s256_x;
        mul_b   = arw_m_r;
      end
      S_AVY: begin
        mul_val  = avg_y_r - s256_y;
        mul_b    = arw_m_r;
        s256_sel = s256_y;
      end
      default: ;
    endcase
  end

  assign mul_neg = mul_val[AVG_W-1];
  assign mul_mag = mul_neg ? -mul_val : mul_val;
  assign mul_a   = mul_mag[MUL_A_W-1:0];

  // floor of the signed product over 65536
  logic [MUL_P_W:0]   prod_up;
  logic [17:0]        fl_mag;
  logic signed [18:0] sfl, nf;
  logic [FACTOR_W-1:0] f_sat;
  logic signed [AVG_W-1:0] avg_new;

  assign prod_up = {1'b0, mul_prod} + (MUL_P_W+1)'(16'hFFFF);
  assign fl_mag  = mul_neg ? prod_up[MUL_P_W:16] : {1'b0, mul_prod[MUL_P_W-1:16]};
  assign sfl     = mul_neg ? -$signed({1'b0, fl_mag}) : $signed({1'b0, fl_mag});
  assign nf      = $signed({3'b000, f_r}) + sfl;
  assign f_sat   = (nf > 19'sd65535) ? 16'hFFFF : nf[15:0];
  assign avg_new = s256_sel + {{(AVG_W-19){sfl[18]}}, sfl};

  // pointer scaling, truncated toward zero
  logic [16:0]        ptr_mag;
  logic [15:0]        ptr_abs;
  logic signed [15:0] ptr_val;

  assign ptr_mag = mul_prod[24:8];
  assign ptr_abs = (ptr_mag > 17'd32767) ? 16'h7FFF : ptr_mag[15:0];
  assign ptr_val = mul_neg ? -$signed(ptr_abs) : $signed(ptr_abs);

  // scroll division operands and results
  logic signed [9:0] t_sel, t_mag;
  logic              div_neg;
  logic [7:0]        d_raw;
  logic [6:0]        q_sat;
  logic signed [7:0] q_pos;
  logic signed [REM_W-1:0] rem_new;

  always_comb begin
    if (state_r == S_DIVV) begin
      t_sel = {rem_v_r[REM_W-1], rem_v_r} + {{2{sy_r[7]}}, sy_r};
      d_raw = div_v_r;
    end else begin
      t_sel = {rem_h_r[REM_W-1], rem_h_r} + {{2{sx_r[7]}}, sx_r};
      d_raw = div_h_r;
    end
  end

  assign div_neg = t_sel[9];
  assign t_mag   = div_neg ? -t_sel : t_sel;
  assign div_n   = t_mag[DIV_N_W-1:0];
  assign div_d   = (d_raw == 8'd0) ? 8'd1 : d_raw;
  assign q_sat   = (div_quo > 9'd127) ? 7'h7F : div_quo[6:0];
  assign q_pos   = $signed({1'b0, q_sat});
  assign rem_new = div_neg ? -$signed({1'b0, div_rem}) : $signed({1'b0, div_rem});

  // arrow accumulation along the dominant direction
  logic [AVG_W-1:0]        abs_ax, abs_ay;
  logic signed [ACC_W:0]   sum_x, sum_y;
  logic signed [ACC_W-1:0] clp_x, clp_y, pre_x, pre_y;
  logic [STEP_W-1:0]       step_eff;
  tap_t                    tap_x, tap_y;

  assign abs_ax   = avg_x_r[AVG_W-1] ? -avg_x_r : avg_x_r;
  assign abs_ay   = avg_y_r[AVG_W-1] ? -avg_y_r : avg_y_r;
  assign sum_x    = {acc_x_r[ACC_W-1], acc_x_r} + {{(ACC_W+1-SAMPLE_W){sx_r[7]}}, sx_r};
  assign sum_y    = {acc_y_r[ACC_W-1], acc_y_r} + {{(ACC_W+1-SAMPLE_W){sy_r[7]}}, sy_r};
  assign clp_x    = (sum_x > 13'sd2047) ? 12'sd2047 :
                    (sum_x < -13'sd2048) ? -12'sd2048 : sum_x[ACC_W-1:0];
  assign clp_y    = (sum_y > 13'sd2047) ? 12'sd2047 :
                    (sum_y < -13'sd2048) ? -12'sd2048 : sum_y[ACC_W-1:0];
  assign step_eff = (step_r == '0) ? STEP_W'(1) : step_r;

  always_comb begin
    pre_x = acc_x_r;
    pre_y = acc_y_r;
    if (abs_ax > abs_ay) begin
      pre_x = clp_x;
      pre_y = '0;
    end else if (abs_ay > abs_ax) begin
      pre_x = '0;
      pre_y = clp_y;
    end
  end

  assign tap_x = arrow_tap(pre_x, step_eff);
  assign tap_y = arrow_tap(pre_y, step_eff);

  // sequencer next state and unit starts
  always_comb begin
    state_nxt  = state_r;
    mul_start  = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_SQ;
      S_SQ:   state_nxt = S_SQRT;
      S_SQRT: begin
        sqrt_start = !launched_r;
        if (sqrt_done) state_nxt = S_SPD;
      end
      S_SPD: begin
        mul_start = !launched_r;
        if (mul_done) state_nxt = S_PX;
      end
      S_PX: begin
        mul_start = !launched_r;
        if (mul_done) state_nxt = S_PY;
      end
      S_PY: begin
        mul_start = !launched_r;
        if (mul_done) state_nxt = base_r ? S_DIVH : S_AVX;
      end
      S_DIVH: begin
        div_start = !launched_r;
        if (div_done) state_nxt = S_DIVV;
      end
      S_DIVV: begin
        div_start = !launched_r;
        if (div_done) state_nxt = S_OUT;
      end
      S_AVX: begin
        mul_start = !launched_r;
        if (mul_done) state_nxt = S_AVY;
      end
      S_AVY: begin
        mul_start = !launched_r;
        if (mul_done) state_nxt = S_ACC;
      end
      S_ACC: state_nxt = S_OUT;
      S_OUT: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register and unit launch flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      launched_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mul_done || sqrt_done || div_done) launched_r <= 1'b0;
      else if (mul_start || sqrt_start || div_start) launched_r <= 1'b1;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_time_r <= RST_IDLE_TIME;
      div_h_r     <= RST_SCROLL_DIV;
      div_v_r     <= RST_SCROLL_DIV;
      step_r      <= RST_ARROW_STEP;
      max_r       <= RST_MAX_SCALE;
      min_r       <= RST_MIN_SCALE;
      spd_m_r     <= RST_SPEED_MOM;
      arw_m_r     <= RST_ARROW_MOM;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_IDLE_TIME:    idle_time_r <= cfg_wdata;
        REG_SCROLL_DIV_H: div_h_r     <= cfg_wdata[7:0];
        REG_SCROLL_DIV_V: div_v_r     <= cfg_wdata[7:0];
        REG_ARROW_STEP:   step_r      <= cfg_wdata[STEP_W-1:0];
        REG_MAX_SCALE:    max_r       <= cfg_wdata;
        REG_MIN_SCALE:    min_r       <= cfg_wdata;
        REG_SPEED_MOM:    spd_m_r     <= cfg_wdata;
        REG_ARROW_MOM:    arw_m_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // persistent state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) prev_r[i] <= '0;
      f_r     <= RST_MIN_SCALE;
      rem_h_r <= '0;
      rem_v_r <= '0;
      avg_x_r <= '0;
      avg_y_r <= '0;
      acc_x_r <= '0;
      acc_y_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: if (in_fire) begin
          if (same) f_r <= min_r;
          for (int i = 0; i < 4; i++) prev_r[i] <= raw[i];
        end
        S_SPD:  if (mul_done) f_r <= f_sat;
        S_DIVH: if (div_done) rem_h_r <= rem_new;
        S_DIVV: if (div_done) rem_v_r <= rem_new;
        S_AVX:  if (mul_done) avg_x_r <= avg_new;
        S_AVY:  if (mul_done) avg_y_r <= avg_new;
        S_ACC: begin
          acc_x_r <= tap_x.acc;
          acc_y_r <= tap_y.acc;
        end
        default: ;
      endcase
    end
  end

  // per-sample work registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (in_fire) begin
        base_r  <= in_tuser[0];
        px_r    <= in_tuser[1] ? raw[0] : raw[2];
        py_r    <= in_tuser[1] ? raw[1] : raw[3];
        sx_r    <= in_tuser[1] ? raw[2] : raw[0];
        sy_r    <= in_tuser[1] ? raw[3] : raw[1];
        scr_h_r <= '0;
        scr_v_r <= '0;
        arw_h_r <= ARROW_NONE;
        arw_v_r <= ARROW_NONE;
      end
      S_SQ:   sumsq_r <= $unsigned(16'(px_r) * 16'(px_r)) +
                         $unsigned(16'(py_r) * 16'(py_r));
      S_SQRT: if (sqrt_done) len_r <= sqrt_root;
      S_PX:   if (mul_done) ptr_x_r <= ptr_val;
      S_PY:   if (mul_done) ptr_y_r <= ptr_val;
      S_DIVH: if (div_done) scr_h_r <= div_neg ? q_pos : -q_pos;
      S_DIVV: if (div_done) scr_v_r <= div_neg ? -q_pos : q_pos;
      S_ACC: begin
        arw_h_r <= tap_x.code;
        arw_v_r <= tap_y.code;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_data_r <= {4'b0000, arw_v_r, arw_h_r, scr_v_r, scr_h_r, ptr_y_r, ptr_x_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // arithmetic units
  tbmp_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  tbmp_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand ({sumsq_r, 16'h0000}),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  tbmp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // checks
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_SQ)
    else $error("accepted transaction did not start work");

  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_SPD || state_r == S_PX || state_r == S_PY ||
                  state_r == S_AVX || state_r == S_AVY))
    else $error("multiplier finished outside a multiply step");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && out_free |=> out_tvalid && state_r == S_IDLE)
    else $error("result not presented after completion");

endmodule
